// ----- hw/rtl/dmrd_pkg.sv -----
// ----------------------------------------------------------------------------
// dmrd_pkg
// shared types, codes and stream layout of the dc motor ramp drive control
// ----------------------------------------------------------------------------
package dmrd_pkg;

    // default ceiling of the manual ramp level
    localparam int LEVEL_MAX_DEF = 255;

    // ramp step saturates here
    localparam logic [7:0] STEP_MAX = 8'd255;

    // duty mapping: pct * 255 / 100 == (pct * 255 * 5243) >> 19 for pct < 128
    localparam int          DUTY_W      = 7;
    localparam int          RECIP_W     = 21;
    localparam int          DUTY_SHIFT  = 19;
    localparam int          PROD_W      = DUTY_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DUTY_RECIP = RECIP_W'(255 * 5243);

    // drive modes and commands
    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_FWD     = 2'd1;
    localparam logic [1:0] CMD_REV     = 2'd2;

    // direction flag codes
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2,
        DIR_STOP = 2'd3
    } t_dir;

    // stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // result beat bit positions
    localparam int OUT_DIR_LSB   = 0;
    localparam int OUT_STOP_BIT  = 2;
    localparam int OUT_LVLV_BIT  = 3;
    localparam int OUT_LVL_LSB   = 4;
    localparam int OUT_RVV_BIT   = 12;
    localparam int OUT_RV_BIT    = 13;
    localparam int OUT_DUTYV_BIT = 14;
    localparam int OUT_DUTY_LSB  = 15;

    typedef struct packed {
        logic              emergency;
        logic [1:0]        drive_mode;
        logic [1:0]        drive_command;
        logic [DUTY_W-1:0] auto_duty_percent;
    } t_item;

    typedef struct packed {
        t_dir       dir_write;
        logic       stop_before_dir;
        logic       level_valid;
        logic [7:0] level_out;
        logic       reversal_valid;
        logic       reversal_flag;
        logic       duty_valid;
        logic [7:0] duty_out;
    } t_result;

endpackage

// ----- hw/rtl/dmrd_ramp.sv -----
// ----------------------------------------------------------------------------
// dmrd_ramp
// motor state registers and the per-tick ramp, direction and duty logic
// ----------------------------------------------------------------------------
module dmrd_ramp #(
    parameter int LEVEL_MAX = dmrd_pkg::LEVEL_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  dmrd_pkg::t_item    i_item,
    output dmrd_pkg::t_result  o_result
);

    localparam int LW = $clog2(LEVEL_MAX + 1);
    localparam int SW = ((LW > 10) ? LW : 10) + 1;

    logic [LW-1:0] r_level, n_level;
    logic [7:0]    r_step,  n_step;
    logic          r_fwd,   n_fwd;
    logic          r_rev,   n_rev;
    logic          r_jrev,  n_jrev;

    logic [7:0]                    step_g;
    logic                          was_other;
    logic                          dir_cmd;
    logic [SW-1:0]                 lvl_ext;
    logic [SW-1:0]                 up_sum;
    logic [SW-1:0]                 down_dec;
    logic [dmrd_pkg::PROD_W-1:0]   duty_prod;
    logic [8:0]                    duty_q;
    dmrd_pkg::t_result             res;

    always_comb begin
        n_level = r_level;
        n_step  = r_step;
        n_fwd   = r_fwd;
        n_rev   = r_rev;
        n_jrev  = r_jrev;
        res     = '0;
        res.dir_write = dmrd_pkg::DIR_NONE;

        step_g    = (r_step == dmrd_pkg::STEP_MAX) ? r_step : r_step + 8'd1;
        dir_cmd   = (i_item.drive_command == dmrd_pkg::CMD_FWD) ||
                    (i_item.drive_command == dmrd_pkg::CMD_REV);
        was_other = (i_item.drive_command == dmrd_pkg::CMD_FWD) ? r_rev : r_fwd;
        lvl_ext   = SW'(r_level);
        // half the climb right after a reversal
        up_sum    = lvl_ext + (was_other ? SW'(step_g) : SW'({step_g, 1'b0}));
        down_dec  = SW'({step_g, 2'b00});

        duty_prod = dmrd_pkg::PROD_W'(i_item.auto_duty_percent) *
                    dmrd_pkg::PROD_W'(dmrd_pkg::DUTY_RECIP);
        duty_q    = duty_prod[dmrd_pkg::PROD_W-1:dmrd_pkg::DUTY_SHIFT];

        if (i_item.emergency) begin
            res.dir_write = dmrd_pkg::DIR_STOP;
            n_level       = '0;
        end else if (i_item.drive_mode == dmrd_pkg::MODE_MANUAL && dir_cmd) begin
            n_fwd  = (i_item.drive_command == dmrd_pkg::CMD_FWD);
            n_rev  = (i_item.drive_command == dmrd_pkg::CMD_REV);
            n_jrev = was_other;
            if (i_item.drive_command == dmrd_pkg::CMD_REV) begin
                res.reversal_valid = 1'b1;
                res.reversal_flag  = was_other;
            end
            if (r_level == '0) begin
                res.dir_write = (i_item.drive_command == dmrd_pkg::CMD_FWD) ?
                                dmrd_pkg::DIR_FWD : dmrd_pkg::DIR_REV;
            end
            if (up_sum >= SW'(LEVEL_MAX)) begin
                n_level = LW'(LEVEL_MAX);
                n_step  = '0;
            end else begin
                n_level = LW'(up_sum);
                n_step  = step_g;
            end
            res.level_valid = 1'b1;
            res.level_out   = 8'(n_level);
        end else if (i_item.drive_mode == dmrd_pkg::MODE_MANUAL &&
                     i_item.drive_command == dmrd_pkg::CMD_NONE) begin
            // floor of the ramp-down is one, not zero
            if (lvl_ext <= down_dec) begin
                n_level = LW'(1);
                n_step  = '0;
            end else begin
                n_level = LW'(lvl_ext - down_dec);
                n_step  = step_g;
            end
            res.level_valid = 1'b1;
            res.level_out   = 8'(n_level);
        end else if (i_item.drive_mode == dmrd_pkg::MODE_AUTO && dir_cmd) begin
            n_fwd  = (i_item.drive_command == dmrd_pkg::CMD_FWD);
            n_rev  = (i_item.drive_command == dmrd_pkg::CMD_REV);
            n_jrev = was_other;
            res.reversal_valid = 1'b1;
            res.reversal_flag  = was_other;
            if (was_other) begin
                n_level = '0;
            end
            if (was_other || r_level == '0) begin
                res.stop_before_dir = was_other;
                res.dir_write = (i_item.drive_command == dmrd_pkg::CMD_FWD) ?
                                dmrd_pkg::DIR_FWD : dmrd_pkg::DIR_REV;
            end
            res.duty_valid = 1'b1;
            res.duty_out   = (duty_q > 9'd255) ? 8'd255 : duty_q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_step  <= '0;
            r_fwd   <= 1'b0;
            r_rev   <= 1'b0;
            r_jrev  <= 1'b0;
        end else if (i_load) begin
            r_level <= n_level;
            r_step  <= n_step;
            r_fwd   <= n_fwd;
            r_rev   <= n_rev;
            r_jrev  <= n_jrev;
        end
    end

    assign o_result = res;

endmodule

// ----- hw/rtl/dmrd_out_reg.sv -----
// ----------------------------------------------------------------------------
// dmrd_out_reg
// result register with valid/ready toward the output stream
// ----------------------------------------------------------------------------
module dmrd_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  dmrd_pkg::t_result  i_result,
    output logic               o_ready,
    output logic               o_valid,
    output dmrd_pkg::t_result  o_result,
    input  logic               i_ready
);

    logic              r_valid;
    dmrd_pkg::t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hw/rtl/dc_motor_ramp_drive_control_core.sv -----
// ----------------------------------------------------------------------------
// dc_motor_ramp_drive_control_core
// per-tick dc motor drive control: emergency stop, manual ramp, auto duty
// ----------------------------------------------------------------------------
// path: an accepted input beat is held in the input register, its result in the
//   result register on m_tdata; throughput: one beat per cycle while m_tready
//   holds, set by the input register -> ramp logic -> result register path; the
//   ramp state updates as each beat leaves the input register; the next beat sees it
// reset: i_rst_n synchronous active low; clears the ramp level, step, direction
//   and reversal flags and empties both pipeline registers
module dc_motor_ramp_drive_control_core #(
    parameter int LEVEL_MAX = dmrd_pkg::LEVEL_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] emergency, [2:1] drive_mode, [4:3] drive_command,
    // [11:5] auto_duty_percent, [15:12] zero
    input  logic [dmrd_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] dir_write, [2] stop_before_dir, [3] level_valid, [11:4] level_out,
    // [12] reversal_valid, [13] reversal_flag, [14] duty_valid,
    // [22:15] duty_out, [23] zero
    output logic [dmrd_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // input register: holds one beat until the result register can take it
    logic              r_in_valid;
    dmrd_pkg::t_item   r_item;

    logic              out_ready;
    logic              advance;
    dmrd_pkg::t_result step_result;
    dmrd_pkg::t_result out_result;

    assign advance  = r_in_valid && out_ready;
    // a new beat comes in whenever the input register is empty or moving on
    assign s_tready = !r_in_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    // unpack the beat, emergency in the lowest bit
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_item.emergency         <= s_tdata[0];
            r_item.drive_mode        <= s_tdata[2:1];
            r_item.drive_command     <= s_tdata[4:3];
            r_item.auto_duty_percent <= s_tdata[11:5];
        end
    end

    // ramp state and the per-tick decision logic
    dmrd_ramp #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_ramp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_item   (r_item),
        .o_result (step_result)
    );

    // result register toward the output stream
    dmrd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (advance),
        .i_result (step_result),
        .o_ready  (out_ready),
        .o_valid  (m_tvalid),
        .o_result (out_result),
        .i_ready  (m_tready)
    );

    // pack the result beat, dir_write in the lowest bits
    assign m_tdata = {
        1'b0,
        out_result.duty_out,
        out_result.duty_valid,
        out_result.reversal_flag,
        out_result.reversal_valid,
        out_result.level_out,
        out_result.level_valid,
        out_result.stop_before_dir,
        out_result.dir_write
    };

endmodule

// ----- hw/rtl/dmrd_checker.sv -----
// ----------------------------------------------------------------------------
// dmrd_checker
// port-level checks of the drive control core, bound to the top level
// ----------------------------------------------------------------------------
module dmrd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [dmrd_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic [1:0] dir_f;
    logic       stop_f;
    logic       lvlv_f;
    logic [7:0] lvl_f;
    logic       rvv_f;
    logic       rv_f;
    logic       dutyv_f;
    logic [7:0] duty_f;

    assign dir_f   = m_tdata[dmrd_pkg::OUT_DIR_LSB +: 2];
    assign stop_f  = m_tdata[dmrd_pkg::OUT_STOP_BIT];
    assign lvlv_f  = m_tdata[dmrd_pkg::OUT_LVLV_BIT];
    assign lvl_f   = m_tdata[dmrd_pkg::OUT_LVL_LSB +: 8];
    assign rvv_f   = m_tdata[dmrd_pkg::OUT_RVV_BIT];
    assign rv_f    = m_tdata[dmrd_pkg::OUT_RV_BIT];
    assign dutyv_f = m_tdata[dmrd_pkg::OUT_DUTYV_BIT];
    assign duty_f  = m_tdata[dmrd_pkg::OUT_DUTY_LSB +: 8];

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // stop before a direction only comes with a real direction
    a_stop_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && stop_f |->
            (dir_f == dmrd_pkg::DIR_FWD || dir_f == dmrd_pkg::DIR_REV) && rvv_f && rv_f)
        else $error("stop_before_dir without a reversal and direction");

    // manual level and auto duty never in the same tick, nor a stop before direction with a level
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(lvlv_f && dutyv_f) && !(stop_f && lvlv_f))
        else $error("level and duty published together");

    // fields without their valid read zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (lvlv_f || lvl_f == 8'd0) && (dutyv_f || duty_f == 8'd0) &&
                     (rvv_f || !rv_f))
        else $error("unpublished field not zero");

    // no result and an input that is ready right out of reset
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_tvalid && !(s_tvalid && !s_tready))
        else $error("pipeline not empty after reset");

endmodule

bind dc_motor_ramp_drive_control_core dmrd_checker u_dmrd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dc motor ramp drive control core: a directed
// walk over stops, ramps, reversals and unused codes, then random manual and
// auto sequences under changing backpressure, all results predicted in-bench
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_TICKS = 1700;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    // codes the package leaves unnamed
    localparam logic [1:0] MODE_NONE  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [1:0] CMD_OTHER  = 2'd3;

    logic                             i_clk    = 1'b0;
    logic                             i_rst_n  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // [0] emergency, [2:1] drive_mode, [4:3] drive_command,
    // [11:5] auto_duty_percent, [15:12] zero
    logic [dmrd_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // [1:0] dir_write, [2] stop_before_dir, [3] level_valid, [11:4] level_out,
    // [12] reversal_valid, [13] reversal_flag, [14] duty_valid,
    // [22:15] duty_out, [23] zero
    logic [dmrd_pkg::OUT_TDATA_W-1:0] m_tdata;

    dc_motor_ramp_drive_control_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the drive state
    int unsigned lvl_acc    = 0;
    int unsigned step_acc   = 0;
    bit          heading_fwd = 1'b0;
    bit          heading_rev = 1'b0;
    bit          reversed_q  = 1'b0;

    dmrd_pkg::t_result pending_outcomes[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int n_fail       = 0;
    int n_ticks      = 0;
    int n_results    = 0;
    int n_ceiling    = 0;
    int n_auto_rev   = 0;
    int n_stops      = 0;
    int quiet_cycles = 0;

    function automatic dmrd_pkg::t_item tick_item(bit emg, logic [1:0] mode,
                                                  logic [1:0] cmd, int duty);
        dmrd_pkg::t_item it;
        it.emergency         = emg;
        it.drive_mode        = mode;
        it.drive_command     = cmd;
        it.auto_duty_percent = dmrd_pkg::DUTY_W'(duty);
        return it;
    endfunction

    function automatic dmrd_pkg::t_result outcome(dmrd_pkg::t_dir d, bit stop, bit lv,
                                                  int lvl, bit rvv, bit rv, bit dv, int dt);
        dmrd_pkg::t_result r;
        r.dir_write       = d;
        r.stop_before_dir = stop;
        r.level_valid     = lv;
        r.level_out       = 8'(lvl);
        r.reversal_valid  = rvv;
        r.reversal_flag   = rv;
        r.duty_valid      = dv;
        r.duty_out        = 8'(dt);
        return r;
    endfunction

    // one control tick: advance the drive state and work out the result beat
    function automatic dmrd_pkg::t_result motor_tick_outcome(dmrd_pkg::t_item it);
        dmrd_pkg::t_result r;
        bit                was_other;
        int unsigned       dec;
        int unsigned       dt;
        r = outcome(dmrd_pkg::DIR_NONE, 0, 0, 0, 0, 0, 0, 0);
        was_other = 1'b0;
        if (it.emergency) begin
            r.dir_write = dmrd_pkg::DIR_STOP;
            lvl_acc = 0;
        end else if (it.drive_mode == dmrd_pkg::MODE_MANUAL &&
                     (it.drive_command == dmrd_pkg::CMD_FWD ||
                      it.drive_command == dmrd_pkg::CMD_REV)) begin
            if (it.drive_command == dmrd_pkg::CMD_FWD) begin
                was_other   = heading_rev;
                heading_fwd = 1'b1;
                heading_rev = 1'b0;
            end else begin
                was_other   = heading_fwd;
                heading_rev = 1'b1;
                heading_fwd = 1'b0;
                r.reversal_valid = 1'b1;
                r.reversal_flag  = was_other;
            end
            reversed_q = was_other;
            if (lvl_acc == 0)
                r.dir_write = (it.drive_command == dmrd_pkg::CMD_FWD) ?
                              dmrd_pkg::DIR_FWD : dmrd_pkg::DIR_REV;
            if (step_acc < 255)
                step_acc++;
            lvl_acc += reversed_q ? step_acc : 2 * step_acc;
            if (lvl_acc >= dmrd_pkg::LEVEL_MAX_DEF) begin
                lvl_acc  = dmrd_pkg::LEVEL_MAX_DEF;
                step_acc = 0;
            end
            r.level_valid = 1'b1;
            r.level_out   = lvl_acc[7:0];
        end else if (it.drive_mode == dmrd_pkg::MODE_MANUAL &&
                     it.drive_command == dmrd_pkg::CMD_NONE) begin
            if (step_acc < 255)
                step_acc++;
            dec = 4 * step_acc;
            // the ramp-down floor is one, not zero
            if (lvl_acc <= dec) begin
                lvl_acc  = 1;
                step_acc = 0;
            end else begin
                lvl_acc -= dec;
            end
            r.level_valid = 1'b1;
            r.level_out   = lvl_acc[7:0];
        end else if (it.drive_mode == dmrd_pkg::MODE_AUTO &&
                     (it.drive_command == dmrd_pkg::CMD_FWD ||
                      it.drive_command == dmrd_pkg::CMD_REV)) begin
            if (it.drive_command == dmrd_pkg::CMD_FWD) begin
                was_other   = heading_rev;
                heading_fwd = 1'b1;
                heading_rev = 1'b0;
            end else begin
                was_other   = heading_fwd;
                heading_rev = 1'b1;
                heading_fwd = 1'b0;
            end
            reversed_q       = was_other;
            r.reversal_valid = 1'b1;
            r.reversal_flag  = was_other;
            // auto reversal stops the motor before the new direction
            if (was_other) begin
                r.dir_write = dmrd_pkg::DIR_STOP;
                lvl_acc = 0;
            end
            if (lvl_acc == 0) begin
                r.stop_before_dir = was_other;
                r.dir_write = (it.drive_command == dmrd_pkg::CMD_FWD) ?
                              dmrd_pkg::DIR_FWD : dmrd_pkg::DIR_REV;
            end
            dt = int'(it.auto_duty_percent) * 255 / 100;
            if (dt > 255)
                dt = 255;
            r.duty_valid = 1'b1;
            r.duty_out   = dt[7:0];
        end
        return r;
    endfunction

    // offer one beat, hold it until taken, then queue what it should produce
    task automatic drive_tick(input dmrd_pkg::t_item it, input bit typed,
                              input dmrd_pkg::t_result want);
        dmrd_pkg::t_result predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, it.auto_duty_percent, it.drive_command, it.drive_mode,
                     it.emergency};
        do @(posedge i_clk); while (!s_tready);
        predicted = motor_tick_outcome(it);
        pending_outcomes.push_back(typed ? want : predicted);
        n_ticks++;
    endtask

    int n_random = 0;

    task automatic random_tick(bit emg, logic [1:0] mode, logic [1:0] cmd, int duty);
        case (n_random * 4 / RANDOM_TICKS)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
            default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
        endcase
        drive_tick(tick_item(emg, mode, cmd, duty), 1'b0, '0);
        // beats the block merely ignores do not count toward the total
        if (emg || (mode == dmrd_pkg::MODE_MANUAL && cmd != CMD_OTHER) ||
            (mode == dmrd_pkg::MODE_AUTO &&
             (cmd == dmrd_pkg::CMD_FWD || cmd == dmrd_pkg::CMD_REV)))
            n_random++;
    endtask

    function automatic int rand_duty();
        return ($urandom_range(9) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
    endfunction

    // result side: check every accepted beat, stall at random
    always @(posedge i_clk) begin
        dmrd_pkg::t_result got;
        dmrd_pkg::t_result want;
        bit                bad;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.dir_write       = dmrd_pkg::t_dir'(m_tdata[dmrd_pkg::OUT_DIR_LSB +: 2]);
            got.stop_before_dir = m_tdata[dmrd_pkg::OUT_STOP_BIT];
            got.level_valid     = m_tdata[dmrd_pkg::OUT_LVLV_BIT];
            got.level_out       = m_tdata[dmrd_pkg::OUT_LVL_LSB +: 8];
            got.reversal_valid  = m_tdata[dmrd_pkg::OUT_RVV_BIT];
            got.reversal_flag   = m_tdata[dmrd_pkg::OUT_RV_BIT];
            got.duty_valid      = m_tdata[dmrd_pkg::OUT_DUTYV_BIT];
            got.duty_out        = m_tdata[dmrd_pkg::OUT_DUTY_LSB +: 8];
            n_results++;
            if (got.level_valid && got.level_out == 8'd255)
                n_ceiling++;
            if (got.stop_before_dir)
                n_auto_rev++;
            if (got.dir_write == dmrd_pkg::DIR_STOP)
                n_stops++;
            if (pending_outcomes.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("result beat %h with nothing outstanding", m_tdata);
            end else begin
                want = pending_outcomes.pop_front();
                bad = (got.dir_write       !== want.dir_write)       ||
                      (got.stop_before_dir !== want.stop_before_dir) ||
                      (got.level_valid     !== want.level_valid)     ||
                      (got.level_out       !== want.level_out)       ||
                      (got.reversal_valid  !== want.reversal_valid)  ||
                      (got.reversal_flag   !== want.reversal_flag)   ||
                      (got.duty_valid      !== want.duty_valid)      ||
                      (got.duty_out        !== want.duty_out);
                if (bad) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS) begin
                        $display("result %0d mismatch: dir/stop lvl_v/lvl rev_v/rev duty_v/duty",
                                 n_results);
                        $display("  exp %0d/%0b %0b/%0d %0b/%0b %0b/%0d",
                                 want.dir_write, want.stop_before_dir, want.level_valid,
                                 want.level_out, want.reversal_valid, want.reversal_flag,
                                 want.duty_valid, want.duty_out);
                        $display("  got %0d/%0b %0b/%0d %0b/%0b %0b/%0d",
                                 got.dir_write, got.stop_before_dir, got.level_valid,
                                 got.level_out, got.reversal_valid, got.reversal_flag,
                                 got.duty_valid, got.duty_out);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog: too long with no beat moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_outcomes.size());
            $display("[dc_motor_ramp_drive_control_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    typedef struct {
        dmrd_pkg::t_item   it;
        int                reps;
        bit                typed;
        dmrd_pkg::t_result want;
    } t_tick_row;

    t_tick_row plan[$];

    task automatic plan_row(bit emg, logic [1:0] mode, logic [1:0] cmd, int duty,
                            int reps, bit typed, dmrd_pkg::t_result want);
        t_tick_row row;
        row.it    = tick_item(emg, mode, cmd, duty);
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    initial begin
        dmrd_pkg::t_result idle_res;
        int                kind;
        int                len;
        logic [1:0]        dirc;
        idle_res = outcome(dmrd_pkg::DIR_NONE, 0, 0, 0, 0, 0, 0, 0);

        // ramp-down from zero lands on the floor of one
        plan_row(0, dmrd_pkg::MODE_MANUAL, dmrd_pkg::CMD_NONE, 0, 1, 1,
                 outcome(dmrd_pkg::DIR_NONE, 0, 1, 1, 0, 0, 0, 0));
        // emergency wins over everything, all other fields at their maximum
        plan_row(1, MODE_SPARE, CMD_OTHER, 127, 1, 1,
                 outcome(dmrd_pkg::DIR_STOP, 0, 0, 0, 0, 0, 0, 0));
        // level zero after the stop, so the direction is written
        plan_row(0, dmrd_pkg::MODE_MANUAL, dmrd_pkg::CMD_FWD, 0, 1, 1,
                 outcome(dmrd_pkg::DIR_FWD, 0, 1, 2, 0, 0, 0, 0));
        // accelerate into the level ceiling
        plan_row(0, dmrd_pkg::MODE_MANUAL, dmrd_pkg::CMD_FWD, 127, 15, 0, idle_res);
        // manual reversal at the ceiling, single step growth
        plan_row(0, dmrd_pkg::MODE_MANUAL, dmrd_pkg::CMD_REV, 64, 1, 0, idle_res);
        plan_row(0, dmrd_pkg::MODE_MANUAL, dmrd_pkg::CMD_NONE, 0, 2, 0, idle_res);
        // unused codes do nothing
        plan_row(0, dmrd_pkg::MODE_MANUAL, CMD_OTHER, 0, 1, 1, idle_res);
        plan_row(0, MODE_NONE, dmrd_pkg::CMD_FWD, 100, 1, 1, idle_res);
        plan_row(0, MODE_SPARE, dmrd_pkg::CMD_REV, 127, 1, 1, idle_res);
        // auto reversal: stop, then the new direction, full duty
        plan_row(0, dmrd_pkg::MODE_AUTO, dmrd_pkg::CMD_FWD, 100, 1, 1,
                 outcome(dmrd_pkg::DIR_FWD, 1, 0, 0, 1, 1, 1, 255));
        plan_row(0, dmrd_pkg::MODE_AUTO, dmrd_pkg::CMD_FWD, 0, 1, 1,
                 outcome(dmrd_pkg::DIR_FWD, 0, 0, 0, 1, 0, 1, 0));
        // duty above one hundred percent saturates
        plan_row(0, dmrd_pkg::MODE_AUTO, dmrd_pkg::CMD_FWD, 127, 1, 1,
                 outcome(dmrd_pkg::DIR_FWD, 0, 0, 0, 1, 0, 1, 255));
        plan_row(0, dmrd_pkg::MODE_AUTO, dmrd_pkg::CMD_REV, 1, 1, 1,
                 outcome(dmrd_pkg::DIR_REV, 1, 0, 0, 1, 1, 1, 2));
        plan_row(0, dmrd_pkg::MODE_AUTO, dmrd_pkg::CMD_NONE, 50, 1, 1, idle_res);
        // manual reverse from rest, then forward with the half step
        plan_row(0, dmrd_pkg::MODE_MANUAL, dmrd_pkg::CMD_REV, 0, 1, 0, idle_res);
        plan_row(0, dmrd_pkg::MODE_MANUAL, dmrd_pkg::CMD_FWD, 0, 1, 0, idle_res);
        plan_row(1, dmrd_pkg::MODE_MANUAL, dmrd_pkg::CMD_NONE, 0, 1, 1,
                 outcome(dmrd_pkg::DIR_STOP, 0, 0, 0, 0, 0, 0, 0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i])
            repeat (plan[i].reps)
                drive_tick(plan[i].it, plan[i].typed, plan[i].want);

        // random part: mostly ramp and auto sequences, some stops and noise
        while (n_random < RANDOM_TICKS) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                dirc = $urandom_range(1) ? dmrd_pkg::CMD_FWD : dmrd_pkg::CMD_REV;
                len  = $urandom_range(1, 18);
                repeat (len)
                    random_tick(0, dmrd_pkg::MODE_MANUAL, dirc, $urandom_range(127));
                len = $urandom_range(0, 12);
                repeat (len)
                    random_tick(0, dmrd_pkg::MODE_MANUAL, dmrd_pkg::CMD_NONE,
                                $urandom_range(127));
            end else if (kind < 65) begin
                len = $urandom_range(1, 6);
                repeat (len)
                    random_tick(0, dmrd_pkg::MODE_AUTO,
                                $urandom_range(1) ? dmrd_pkg::CMD_FWD : dmrd_pkg::CMD_REV,
                                rand_duty());
            end else if (kind < 75) begin
                random_tick(1, 2'($urandom_range(3)), 2'($urandom_range(3)),
                            $urandom_range(127));
            end else if (kind < 88) begin
                len = $urandom_range(1, 10);
                repeat (len)
                    random_tick(0, dmrd_pkg::MODE_MANUAL, 2'($urandom_range(3)),
                                $urandom_range(127));
            end else begin
                random_tick(1'($urandom_range(1)), 2'($urandom_range(3)),
                            2'($urandom_range(3)), $urandom_range(127));
            end
        end
        s_tvalid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d ticks sent, %0d results checked, %0d mismatches", n_ticks, n_results,
                 n_fail);
        $display("%0d at the level ceiling, %0d auto reversals, %0d stop writes",
                 n_ceiling, n_auto_rev, n_stops);
        if (n_fail == 0 && pending_outcomes.size() == 0) begin
            $display("[dc_motor_ramp_drive_control_core] OK");
        end else begin
            $display("[dc_motor_ramp_drive_control_core] ERROR");
        end
        $finish;
    end

endmodule
